### rtl/core/tao_pkg.sv
// ----------------------------------------------------------------------------
// Attention engine package
// Shared types, constants and the exponential helper.
// ----------------------------------------------------------------------------
package tao_pkg;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_SEQ_LEN     = 2'd0;
   localparam logic [1:0] CSR_HEAD_DIM    = 2'd1;
   localparam logic [1:0] CSR_SCORE_SCALE = 2'd2;

   localparam logic [8:0]  SEQ_LEN_RST     = 9'd256;
   localparam logic [6:0]  HEAD_DIM_RST    = 7'd64;
   localparam logic [15:0] SCORE_SCALE_RST = 16'd8192;

   // action codes of an input item
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam int DOT_W     = 38;   // sum of up to 64 Q8.24 products
   localparam int ACC_W     = 48;
   localparam int P_W       = 17;   // weight in Q1.16
   localparam int DIFF_W    = 33;
   localparam int T_W       = 34;
   localparam int DIV_STEPS = 48;

   localparam logic [12:0] LOG2E_Q12 = 13'd5909;
   localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

   // 2^(-i/16) in Q.16
   localparam logic [16:0] POW2_TAB [17] = '{
      17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
      17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
      17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
   };

   typedef struct packed {
      logic       valid;
      logic [7:0] tag;
   } tao_job_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_BLK, ST_DOT_START, ST_DOT_RD, ST_DOT_MUL, ST_DOT_ACC,
      ST_SC_LO, ST_SC_HI, ST_SC_SUM, ST_EXP_RD, ST_EXP_D, ST_EXP_T, ST_EXP_P,
      ST_ALPHA_D, ST_ALPHA_T, ST_ALPHA_P, ST_SUM_MUL, ST_SUM_UPD, ST_ACC_RD,
      ST_ACC_LO, ST_ACC_HI, ST_ACC_SC, ST_PV_RD, ST_PV_MUL, ST_PV_ACC, ST_ACC_WR,
      ST_BLK_END, ST_OUT_RD, ST_DIV_INIT, ST_DIV, ST_OUT
   } tao_state_type;

   // e^(-x) from the base-two exponent t (12 fraction bits), Q1.16
   function automatic logic [16:0] exp_q16(input logic [T_W-1:0] t);
      logic [21:0] n;
      logic [3:0]  i;
      logic [7:0]  r;
      logic [16:0] hi;
      logic [16:0] lo;
      logic [16:0] v;
      logic [19:0] dr;
      n  = t[33:12];
      i  = t[11:8];
      r  = t[7:0];
      hi = POW2_TAB[i];
      lo = POW2_TAB[5'(i) + 5'd1];
      dr = 20'(hi - lo) * 20'(r);
      v  = hi - 17'(dr >> 8);
      if (n > 22'd16) begin
         exp_q16 = '0;
      end else begin
         exp_q16 = v >> n[4:0];
      end
   endfunction

endpackage

### rtl/core/tao_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying load and query items.
// ----------------------------------------------------------------------------
interface tao_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic [7:0]         row;
   logic [5:0]         col;
   logic signed [15:0] qk_value;
   logic signed [15:0] v_value;

   modport source (output valid, action, row, col, qk_value, v_value, input ready);
   modport sink (input valid, action, row, col, qk_value, v_value, output ready);
endinterface

### rtl/core/tao_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying attention output items.
// ----------------------------------------------------------------------------
interface tao_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         query_row;
   logic [5:0]         out_col;
   logic signed [15:0] out_value;
   logic               last;

   modport source (output valid, query_row, out_col, out_value, last, input ready);
   modport sink (input valid, query_row, out_col, out_value, last, output ready);
endinterface

### rtl/core/tao_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tao_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/core/tao_front.sv
// ----------------------------------------------------------------------------
// Attention front end
// Accept items, store key, value and query elements, queue completed queries.
// ----------------------------------------------------------------------------
module tao_front #(
   parameter int MAX_SEQ = 256,
   parameter int MAX_DIM = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   tao_req_if.sink                 req_chan,
   input  logic [6:0]              dim,
   input  logic                    back_busy,
   input  logic                    job_take,
   output tao_pkg::tao_job_type    job,
   output logic                    kv_we,
   output logic [((MAX_SEQ*MAX_DIM > 1) ? $clog2(MAX_SEQ*MAX_DIM) : 1)-1:0] kv_waddr,
   output logic [15:0]             k_wdata,
   output logic [15:0]             v_wdata,
   output logic                    q_we,
   output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] q_waddr,
   output logic [15:0]             q_wdata
);
   import tao_pkg::*;

   localparam int KV_AW = (MAX_SEQ*MAX_DIM > 1) ? $clog2(MAX_SEQ*MAX_DIM) : 1;
   localparam int QA_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic       job_valid_ff, job_valid_in;
   logic [7:0] job_tag_ff, job_tag_in;
   logic       accept, push;

   assign req_chan.ready = !job_valid_ff && !back_busy;
   assign accept = req_chan.valid && req_chan.ready;

   assign kv_we    = accept && (req_chan.action == ACT_LOAD)
                     && (32'(req_chan.row) < MAX_SEQ) && (32'(req_chan.col) < MAX_DIM);
   assign kv_waddr = KV_AW'(32'(req_chan.row) * MAX_DIM + 32'(req_chan.col));
   assign k_wdata  = req_chan.qk_value;
   assign v_wdata  = req_chan.v_value;

   assign q_we    = accept && (req_chan.action == ACT_QUERY) && (32'(req_chan.col) < MAX_DIM);
   assign q_waddr = QA_W'(req_chan.col);
   assign q_wdata = req_chan.qk_value;

   // the element at head_dim-1 completes the row
   assign push = accept && (req_chan.action == ACT_QUERY)
                 && (7'(req_chan.col) == dim - 7'd1);

   always_comb begin
      job_valid_in = job_valid_ff;
      job_tag_in   = job_tag_ff;
      if (job_take) begin
         job_valid_in = 1'b0;
      end
      if (push) begin
         job_valid_in = 1'b1;
         job_tag_in   = req_chan.row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
      job_tag_ff <= job_tag_in;
   end

   assign job.valid = job_valid_ff;
   assign job.tag   = job_tag_ff;

   a_no_accept_with_job: assert property (@(posedge clock) disable iff (reset)
      accept |-> !job_valid_ff) else $error("item accepted while a query is queued");
   a_push_queues: assert property (@(posedge clock) disable iff (reset)
      push |=> job_valid_ff) else $error("completed query not queued");
   a_job_holds: assert property (@(posedge clock) disable iff (reset)
      (job_valid_ff && !job_take) |=> (job_valid_ff && $stable(job_tag_ff)))
      else $error("queued query lost");
endmodule

### rtl/core/tao_back.sv
// ----------------------------------------------------------------------------
// Attention back end
// Score keys, run online softmax per key block, divide and emit outputs.
// ----------------------------------------------------------------------------
module tao_back #(
   parameter int MAX_SEQ   = 256,
   parameter int MAX_DIM   = 64,
   parameter int KEY_BLOCK = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tao_pkg::tao_job_type          job,
   output logic                          job_take,
   output logic                          busy,
   input  logic [$clog2(MAX_SEQ+1)-1:0]  seq,
   input  logic [6:0]                    dim,
   input  logic [15:0]                   scale,
   output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] q_raddr,
   input  logic [15:0]                   q_rdata,
   output logic [((MAX_SEQ*MAX_DIM > 1) ? $clog2(MAX_SEQ*MAX_DIM) : 1)-1:0] kv_raddr,
   input  logic [15:0]                   k_rdata,
   input  logic [15:0]                   v_rdata,
   tao_rsp_if.source                     rsp_chan
);
   import tao_pkg::*;

   localparam int SEQ_W = $clog2(MAX_SEQ+1);
   localparam int KV_AW = (MAX_SEQ*MAX_DIM > 1) ? $clog2(MAX_SEQ*MAX_DIM) : 1;
   localparam int QA_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int JA_W  = (KEY_BLOCK > 1) ? $clog2(KEY_BLOCK) : 1;
   localparam int JC_W  = $clog2(KEY_BLOCK+1);

   tao_state_type state_ff, state_in;
   logic [SEQ_W-1:0]         base_ff, base_in;
   logic [JC_W-1:0]          cnt_ff, cnt_in;
   logic [JA_W-1:0]          j_ff, j_in;
   logic [QA_W-1:0]          d_ff, d_in;
   logic                     first_ff, first_in;
   logic [7:0]               tag_ff, tag_in;
   logic signed [31:0]       run_max_ff, run_max_in;
   logic signed [31:0]       new_m_ff, new_m_in;
   logic [31:0]              run_sum_ff, run_sum_in;
   logic [31:0]              sum_exp_ff, sum_exp_in;
   logic [P_W-1:0]           alpha_ff, alpha_in;
   logic signed [33:0]       prod_ff, prod_in;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic [40:0]              mlo_ff, mlo_in;
   logic signed [41:0]       mhi_ff, mhi_in;
   logic [DIFF_W-1:0]        diff_ff, diff_in;
   logic [T_W-1:0]           t_ff, t_in;
   logic [48:0]              sprod_ff, sprod_in;
   logic signed [ACC_W-1:0]  acc_tmp_ff, acc_tmp_in;
   logic [ACC_W-1:0]         div_q_ff, div_q_in;
   logic [32:0]              div_r_ff, div_r_in;
   logic [5:0]               div_cnt_ff, div_cnt_in;
   logic                     div_neg_ff, div_neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_row_ff, rsp_row_in;
   logic [5:0]               rsp_col_ff, rsp_col_in;
   logic [15:0]              rsp_val_ff, rsp_val_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     score_we, pw_we, acc_we;
   logic [31:0]              score_wdata, score_rdata;
   logic [P_W-1:0]           pw_wdata, pw_rdata, p_val;
   logic [ACC_W-1:0]         acc_rdata;
   logic signed [55:0]       sc_total;
   logic signed [65:0]       acc_total;
   logic signed [ACC_W-1:0]  acc_prev, acc_in_val;
   logic signed [31:0]       score_val;
   logic [SEQ_W-1:0]         seq_rem;
   logic                     j_last, d_last, out_free;
   logic [32:0]              div_sh, den33;
   logic [31:0]              den;

   tao_ram #(.WIDTH(32), .DEPTH(KEY_BLOCK)) u_score_ram (
      .clock (clock), .we (score_we), .waddr (j_ff), .wdata (score_wdata),
      .raddr (j_ff), .rdata (score_rdata)
   );
   tao_ram #(.WIDTH(P_W), .DEPTH(KEY_BLOCK)) u_pw_ram (
      .clock (clock), .we (pw_we), .waddr (j_ff), .wdata (pw_wdata),
      .raddr (j_ff), .rdata (pw_rdata)
   );
   tao_ram #(.WIDTH(ACC_W), .DEPTH(MAX_DIM)) u_acc_ram (
      .clock (clock), .we (acc_we), .waddr (d_ff), .wdata (acc_tmp_ff),
      .raddr (d_ff), .rdata (acc_rdata)
   );

   assign q_raddr  = d_ff;
   assign kv_raddr = KV_AW'((32'(base_ff) + 32'(j_ff)) * MAX_DIM + 32'(d_ff));
   assign busy     = (state_ff != ST_IDLE);

   assign j_last   = ((JC_W'(j_ff) + JC_W'(1)) == cnt_ff);
   assign d_last   = ((7'(d_ff) + 7'd1) == dim);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign seq_rem  = seq - base_ff;

   assign sc_total   = (56'(mhi_ff) <<< 19) + 56'($signed({1'b0, mlo_ff}));
   assign score_val  = 32'(sc_total >>> 28);
   assign acc_total  = (66'(mhi_ff) <<< 24) + 66'($signed({1'b0, mlo_ff}));
   assign acc_prev   = first_ff ? '0 : $signed(acc_rdata);
   assign acc_in_val = $signed(acc_rdata);
   assign p_val      = exp_q16(t_ff);
   assign den        = (run_sum_ff == 32'd0) ? 32'd1 : run_sum_ff;
   assign den33      = {1'b0, den};
   assign div_sh     = {div_r_ff[31:0], div_q_ff[ACC_W-1]};

   assign score_wdata = score_val;
   assign pw_wdata    = p_val;

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      j_in         = j_ff;
      d_in         = d_ff;
      first_in     = first_ff;
      tag_in       = tag_ff;
      run_max_in   = run_max_ff;
      new_m_in     = new_m_ff;
      run_sum_in   = run_sum_ff;
      sum_exp_in   = sum_exp_ff;
      alpha_in     = alpha_ff;
      prod_in      = prod_ff;
      dot_in       = dot_ff;
      mlo_in       = mlo_ff;
      mhi_in       = mhi_ff;
      diff_in      = diff_ff;
      t_in         = t_ff;
      sprod_in     = sprod_ff;
      acc_tmp_in   = acc_tmp_ff;
      div_q_in     = div_q_ff;
      div_r_in     = div_r_ff;
      div_cnt_in   = div_cnt_ff;
      div_neg_in   = div_neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;
      job_take     = 1'b0;
      score_we     = 1'b0;
      pw_we        = 1'b0;
      acc_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (job.valid) begin
               job_take = 1'b1;
               tag_in   = job.tag;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            run_max_in = SCORE_MIN;
            run_sum_in = '0;
            base_in    = '0;
            first_in   = 1'b1;
            state_in   = ST_BLK;
         end
         ST_BLK: begin
            cnt_in   = (32'(seq_rem) > 32'(KEY_BLOCK)) ? JC_W'(KEY_BLOCK) : JC_W'(seq_rem);
            j_in     = '0;
            new_m_in = run_max_ff;
            state_in = ST_DOT_START;
         end
         ST_DOT_START: begin
            dot_in   = '0;
            d_in     = '0;
            state_in = ST_DOT_RD;
         end
         ST_DOT_RD: begin
            state_in = ST_DOT_MUL;
         end
         ST_DOT_MUL: begin
            prod_in  = 34'($signed(q_rdata)) * 34'($signed(k_rdata));
            state_in = ST_DOT_ACC;
         end
         ST_DOT_ACC: begin
            dot_in = dot_ff + DOT_W'(prod_ff);
            if (d_last) begin
               state_in = ST_SC_LO;
            end else begin
               d_in     = d_ff + QA_W'(1);
               state_in = ST_DOT_RD;
            end
         end
         ST_SC_LO: begin
            mlo_in   = 41'(dot_ff[18:0]) * 41'(scale);
            state_in = ST_SC_HI;
         end
         ST_SC_HI: begin
            mhi_in   = 42'($signed(dot_ff[37:19])) * 42'($signed({1'b0, scale}));
            state_in = ST_SC_SUM;
         end
         ST_SC_SUM: begin
            score_we = 1'b1;
            if (score_val > new_m_ff) begin
               new_m_in = score_val;
            end
            if (j_last) begin
               j_in       = '0;
               sum_exp_in = '0;
               state_in   = ST_EXP_RD;
            end else begin
               j_in     = j_ff + JA_W'(1);
               state_in = ST_DOT_START;
            end
         end
         ST_EXP_RD: begin
            state_in = ST_EXP_D;
         end
         ST_EXP_D: begin
            diff_in  = DIFF_W'(33'(new_m_ff) - 33'($signed(score_rdata)));
            state_in = ST_EXP_T;
         end
         ST_EXP_T: begin
            t_in     = T_W'((46'(diff_ff) * 46'(LOG2E_Q12)) >> 12);
            state_in = ST_EXP_P;
         end
         ST_EXP_P: begin
            pw_we      = 1'b1;
            sum_exp_in = sum_exp_ff + 32'(p_val);
            if (j_last) begin
               state_in = ST_ALPHA_D;
            end else begin
               j_in     = j_ff + JA_W'(1);
               state_in = ST_EXP_RD;
            end
         end
         ST_ALPHA_D: begin
            diff_in  = DIFF_W'(33'(new_m_ff) - 33'(run_max_ff));
            state_in = ST_ALPHA_T;
         end
         ST_ALPHA_T: begin
            t_in     = T_W'((46'(diff_ff) * 46'(LOG2E_Q12)) >> 12);
            state_in = ST_ALPHA_P;
         end
         ST_ALPHA_P: begin
            alpha_in = p_val;
            state_in = ST_SUM_MUL;
         end
         ST_SUM_MUL: begin
            sprod_in = 49'(alpha_ff) * 49'(run_sum_ff);
            state_in = ST_SUM_UPD;
         end
         ST_SUM_UPD: begin
            run_sum_in = 32'(sprod_ff >> 16) + sum_exp_ff;
            d_in       = '0;
            state_in   = ST_ACC_RD;
         end
         ST_ACC_RD: begin
            state_in = ST_ACC_LO;
         end
         ST_ACC_LO: begin
            mlo_in   = 41'(acc_prev[23:0]) * 41'(alpha_ff);
            state_in = ST_ACC_HI;
         end
         ST_ACC_HI: begin
            mhi_in   = 42'($signed(acc_prev[47:24])) * 42'($signed({1'b0, alpha_ff}));
            state_in = ST_ACC_SC;
         end
         ST_ACC_SC: begin
            acc_tmp_in = ACC_W'(acc_total >>> 16);
            j_in       = '0;
            state_in   = ST_PV_RD;
         end
         ST_PV_RD: begin
            state_in = ST_PV_MUL;
         end
         ST_PV_MUL: begin
            prod_in  = 34'($signed({1'b0, pw_rdata})) * 34'($signed(v_rdata));
            state_in = ST_PV_ACC;
         end
         ST_PV_ACC: begin
            acc_tmp_in = acc_tmp_ff + ACC_W'(prod_ff);
            if (j_last) begin
               state_in = ST_ACC_WR;
            end else begin
               j_in     = j_ff + JA_W'(1);
               state_in = ST_PV_RD;
            end
         end
         ST_ACC_WR: begin
            acc_we = 1'b1;
            if (d_last) begin
               state_in = ST_BLK_END;
            end else begin
               d_in     = d_ff + QA_W'(1);
               state_in = ST_ACC_RD;
            end
         end
         ST_BLK_END: begin
            run_max_in = new_m_ff;
            first_in   = 1'b0;
            if (32'(seq_rem) <= 32'(KEY_BLOCK)) begin
               d_in     = '0;
               state_in = ST_OUT_RD;
            end else begin
               base_in  = base_ff + SEQ_W'(KEY_BLOCK);
               state_in = ST_BLK;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            div_neg_in = acc_in_val[ACC_W-1];
            div_q_in   = acc_in_val[ACC_W-1] ? ACC_W'(-acc_in_val) : acc_rdata;
            div_r_in   = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (div_sh >= den33) begin
               div_r_in = div_sh - den33;
               div_q_in = {div_q_ff[ACC_W-2:0], 1'b1};
            end else begin
               div_r_in = div_sh;
               div_q_in = {div_q_ff[ACC_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = tag_ff;
               rsp_col_in   = 6'(d_ff);
               rsp_last_in  = d_last;
               if (div_neg_ff) begin
                  rsp_val_in = (div_q_ff > 48'd32768) ? 16'h8000 : 16'(48'd0 - div_q_ff);
               end else begin
                  rsp_val_in = (div_q_ff > 48'd32767) ? 16'h7FFF : 16'(div_q_ff);
               end
               if (d_last) begin
                  state_in = ST_IDLE;
               end else begin
                  d_in     = d_ff + QA_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff    <= base_in;
      cnt_ff     <= cnt_in;
      j_ff       <= j_in;
      d_ff       <= d_in;
      first_ff   <= first_in;
      tag_ff     <= tag_in;
      run_max_ff <= run_max_in;
      new_m_ff   <= new_m_in;
      run_sum_ff <= run_sum_in;
      sum_exp_ff <= sum_exp_in;
      alpha_ff   <= alpha_in;
      prod_ff    <= prod_in;
      dot_ff     <= dot_in;
      mlo_ff     <= mlo_in;
      mhi_ff     <= mhi_in;
      diff_ff    <= diff_in;
      t_ff       <= t_in;
      sprod_ff   <= sprod_in;
      acc_tmp_ff <= acc_tmp_in;
      div_q_ff   <= div_q_in;
      div_r_ff   <= div_r_in;
      div_cnt_ff <= div_cnt_in;
      div_neg_ff <= div_neg_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_val_ff <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.query_row = rsp_row_ff;
   assign rsp_chan.out_col   = rsp_col_ff;
   assign rsp_chan.out_value = rsp_val_ff;
   assign rsp_chan.last      = rsp_last_ff;

   a_job_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && job.valid) |=> (state_ff == ST_INIT))
      else $error("queued query not started");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_RD) |-> (run_sum_ff != 32'd0))
      else $error("running sum zero at output");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff < 6'(DIV_STEPS)))
      else $error("divider overran");
endmodule

### rtl/core/tiled_attention_online_softmax.sv
// ----------------------------------------------------------------------------
// Tiled attention with online softmax
// One attention head in fixed point: key/value store, query buffer, engine.
// ----------------------------------------------------------------------------
// A load item writes one key and one value element. The query item at column
// head_dim-1 hands the row to the engine, and no further item is taken until
// the engine has finished its last output. The engine is a sequencer that
// works through its arithmetic one state at a time. Each query-key product
// passes a RAM read, a multiply and an accumulate state, each weighted value a
// RAM read, a multiply and an accumulate as well, and each output element a
// 48-step bit-serial divider. Outputs leave through a registered response
// stage that holds one element; while the sink stalls, the engine waits with
// the next one.
module tiled_attention_online_softmax #(
   parameter int MAX_SEQ   = 256,
   parameter int MAX_DIM   = 64,
   parameter int KEY_BLOCK = 32
) (
   input  logic        clock,
   input  logic        reset,
   tao_req_if.sink     req_chan,
   tao_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import tao_pkg::*;

   localparam int SEQ_W = $clog2(MAX_SEQ+1);
   localparam int KV_AW = (MAX_SEQ*MAX_DIM > 1) ? $clog2(MAX_SEQ*MAX_DIM) : 1;
   localparam int QA_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic [8:0]  seq_len_ff, seq_len_in;
   logic [6:0]  head_dim_ff, head_dim_in;
   logic [15:0] scale_ff, scale_in;
   logic [SEQ_W-1:0] seq;
   logic [6:0]  dim;

   tao_job_type job;
   logic        job_take, back_busy;
   logic        kv_we, q_we;
   logic [KV_AW-1:0] kv_waddr, kv_raddr;
   logic [15:0] k_wdata, v_wdata, q_wdata, k_rdata, v_rdata, q_rdata;
   logic [QA_W-1:0]  q_waddr, q_raddr;

   // configuration registers
   always_comb begin
      seq_len_in  = seq_len_ff;
      head_dim_in = head_dim_ff;
      scale_in    = scale_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SEQ_LEN:     seq_len_in  = csr_wdata[8:0];
            CSR_HEAD_DIM:    head_dim_in = csr_wdata[6:0];
            CSR_SCORE_SCALE: scale_in    = csr_wdata;
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff  <= SEQ_LEN_RST;
         head_dim_ff <= HEAD_DIM_RST;
         scale_ff    <= SCORE_SCALE_RST;
      end else begin
         seq_len_ff  <= seq_len_in;
         head_dim_ff <= head_dim_in;
         scale_ff    <= scale_in;
      end
   end

   // clamp lengths: zero counts as one, anything past the store counts as full
   assign seq = (seq_len_ff == 9'd0) ? SEQ_W'(1)
              : ((32'(seq_len_ff) > MAX_SEQ) ? SEQ_W'(MAX_SEQ) : SEQ_W'(seq_len_ff));
   assign dim = (head_dim_ff == 7'd0) ? 7'd1
              : ((32'(head_dim_ff) > MAX_DIM) ? 7'(MAX_DIM) : head_dim_ff);

   tao_front #(.MAX_SEQ(MAX_SEQ), .MAX_DIM(MAX_DIM)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .dim       (dim),
      .back_busy (back_busy),
      .job_take  (job_take),
      .job       (job),
      .kv_we     (kv_we),
      .kv_waddr  (kv_waddr),
      .k_wdata   (k_wdata),
      .v_wdata   (v_wdata),
      .q_we      (q_we),
      .q_waddr   (q_waddr),
      .q_wdata   (q_wdata)
   );

   // key and value rows share one address: entry row*MAX_DIM+col
   tao_ram #(.WIDTH(16), .DEPTH(MAX_SEQ*MAX_DIM)) u_key_ram (
      .clock (clock), .we (kv_we), .waddr (kv_waddr), .wdata (k_wdata),
      .raddr (kv_raddr), .rdata (k_rdata)
   );
   tao_ram #(.WIDTH(16), .DEPTH(MAX_SEQ*MAX_DIM)) u_value_ram (
      .clock (clock), .we (kv_we), .waddr (kv_waddr), .wdata (v_wdata),
      .raddr (kv_raddr), .rdata (v_rdata)
   );
   tao_ram #(.WIDTH(16), .DEPTH(MAX_DIM)) u_query_ram (
      .clock (clock), .we (q_we), .waddr (q_waddr), .wdata (q_wdata),
      .raddr (q_raddr), .rdata (q_rdata)
   );

   tao_back #(.MAX_SEQ(MAX_SEQ), .MAX_DIM(MAX_DIM), .KEY_BLOCK(KEY_BLOCK)) u_back (
      .clock    (clock),
      .reset    (reset),
      .job      (job),
      .job_take (job_take),
      .busy     (back_busy),
      .seq      (seq),
      .dim      (dim),
      .scale    (scale_ff),
      .q_raddr  (q_raddr),
      .q_rdata  (q_rdata),
      .kv_raddr (kv_raddr),
      .k_rdata  (k_rdata),
      .v_rdata  (v_rdata),
      .rsp_chan (rsp_chan)
   );
endmodule

### verif/tb_tiled_attention_online_softmax.sv
// ----------------------------------------------------------------------------
// Attention engine testbench
// Drives load and query items through the request channel, predicts every
// normalised output element with a fixed-point model of the online softmax,
// and checks each response item in order, over several register settings.
// ----------------------------------------------------------------------------
module tb_tiled_attention_online_softmax;
   import tao_pkg::*;

   typedef struct {
      logic [7:0]  query_row;
      logic [5:0]  out_col;
      logic [15:0] out_value;
      logic        last;
   } attn_out_type;

   // fixed-point prediction of the attention head
   class attn_scoreboard;
      int unsigned        seq_len_r;
      int unsigned        head_dim_r;
      int unsigned        scale_r;
      logic signed [15:0] key_mem [256*64];
      logic signed [15:0] val_mem [256*64];
      logic signed [15:0] qbuf [64];
      attn_out_type       expected [$];

      function new();
         seq_len_r  = SEQ_LEN_RST;
         head_dim_r = HEAD_DIM_RST;
         scale_r    = SCORE_SCALE_RST;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_SEQ_LEN: begin
               seq_len_r = data[8:0];
            end
            CSR_HEAD_DIM: begin
               head_dim_r = data[6:0];
            end
            CSR_SCORE_SCALE: begin
               scale_r = data;
            end
            default: begin
            end
         endcase
      endfunction

      // e^(-d/4096) in Q1.16 by way of the base-two table
      function longint exp_weight(longint d);
         longint t;
         longint n;
         longint f;
         longint hi;
         longint lo;
         if (d > (longint'(1) << 40)) return 0;
         t = (d * 5909) >>> 12;
         n = t >>> 12;
         if (n > 16) return 0;
         f  = t & 4095;
         hi = POW2_TAB[f >>> 8];
         lo = POW2_TAB[(f >>> 8) + 1];
         return (hi - (((hi - lo) * (f & 255)) >>> 8)) >>> n;
      endfunction

      function int unsigned eff_dim();
         return head_dim_r == 0 ? 1 : (head_dim_r > 64 ? 64 : head_dim_r);
      endfunction

      function void note(logic act, logic [7:0] row, logic [5:0] col,
                         logic signed [15:0] qk, logic signed [15:0] vv);
         int unsigned  seq;
         int unsigned  dim;
         int unsigned  cnt;
         longint       rmax;
         longint       newm;
         longint       dot;
         longint       alpha;
         longint       add;
         longint       q;
         logic [31:0]  rsum;
         logic [31:0]  sumexp;
         longint       sc [32];
         longint       pw [32];
         longint       acc [64];
         attn_out_type o;
         seq = seq_len_r == 0 ? 1 : (seq_len_r > 256 ? 256 : seq_len_r);
         dim = eff_dim();
         if (act == ACT_LOAD) begin
            key_mem[row*64 + col] = qk;
            val_mem[row*64 + col] = vv;
            return;
         end
         qbuf[col] = qk;
         if (col != dim - 1) return;
         rmax = -(longint'(1) << 31);
         rsum = '0;
         for (int d = 0; d < 64; d++) acc[d] = 0;
         for (int base = 0; base < seq; base += 32) begin
            cnt    = (seq - base < 32) ? seq - base : 32;
            newm   = rmax;
            sumexp = '0;
            for (int j = 0; j < cnt; j++) begin
               dot = 0;
               for (int d = 0; d < dim; d++)
                  dot += longint'(qbuf[d]) * longint'(key_mem[(base+j)*64 + d]);
               sc[j] = (dot * longint'(scale_r)) >>> 28;
               if (sc[j] > newm) newm = sc[j];
            end
            for (int j = 0; j < cnt; j++) begin
               pw[j]  = exp_weight(newm - sc[j]);
               sumexp = sumexp + 32'(pw[j]);
            end
            alpha = exp_weight(newm - rmax);
            rsum  = 32'((alpha * longint'(rsum)) >>> 16) + sumexp;
            for (int d = 0; d < dim; d++) begin
               add = 0;
               for (int j = 0; j < cnt; j++)
                  add += pw[j] * longint'(val_mem[(base+j)*64 + d]);
               acc[d] = ((alpha * acc[d]) >>> 16) + add;
            end
            rmax = newm;
         end
         for (int d = 0; d < dim; d++) begin
            q = acc[d] / (rsum == 0 ? longint'(1) : longint'(rsum));
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            o.query_row = row;
            o.out_col   = 6'(d);
            o.out_value = 16'(q);
            o.last      = (d == dim - 1);
            expected.push_back(o);
         end
      endfunction

      // empty string on a match
      function string check(attn_out_type got);
         attn_out_type w;
         w = expected.pop_front();
         if (got.query_row !== w.query_row || got.out_col !== w.out_col ||
             got.out_value !== w.out_value || got.last !== w.last)
            return $sformatf("row %0d col %0d value %0d last %0d, want %0d %0d %0d %0d",
               got.query_row, got.out_col, $signed(got.out_value), got.last,
               w.query_row, w.out_col, $signed(w.out_value), w.last);
         return "";
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   tao_req_if req_if ();
   tao_rsp_if rsp_if ();

   tiled_attention_online_softmax i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   attn_scoreboard attn_sb;
   int  fail_count;
   int  items_sent;
   int  outputs_seen;
   int  queries_done;
   int  burst_left;
   bit  key_written [256][64];
   bit  q_written [64];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // generous time bound on the whole run
   initial begin
      #(8 * 3_000_000);
      $display("tb: failure");
      $finish;
   end

   task automatic report(string msg);
      $display("tb: mismatch: %s", msg);
      fail_count++;
   endtask

   // favour the extremes of Q4.12 now and then
   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // hold the item until the handshake, then note it and maybe leave a gap
   task automatic send_item(logic act, logic [7:0] row, logic [5:0] col,
                            logic [15:0] qk, logic [15:0] vv);
      req_if.valid    <= 1'b1;
      req_if.action   <= act;
      req_if.row      <= row;
      req_if.col      <= col;
      req_if.qk_value <= qk;
      req_if.v_value  <= vv;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      attn_sb.note(act, row, col, qk, vv);
      items_sent++;
      if (act == ACT_LOAD) key_written[row][col] = 1'b1;
      else q_written[col] = 1'b1;
      if (act == ACT_QUERY && col == attn_sb.eff_dim() - 1) queries_done++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if ($urandom_range(0, 2) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // drop valid and wait until every predicted output has arrived
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (attn_sb.expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_regs(int unsigned seq, int unsigned dim, int unsigned scale);
      logic [15:0] vals [3];
      vals = '{16'(seq), 16'(dim), 16'(scale)};
      for (int i = 0; i < 3; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= 2'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         attn_sb.set_reg(2'(i), vals[i]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // every key/value element the next query reads must exist
   task automatic fill_keys();
      int unsigned seq;
      seq = attn_sb.seq_len_r == 0 ? 1 : (attn_sb.seq_len_r > 256 ? 256 : attn_sb.seq_len_r);
      for (int r = 0; r < seq; r++)
         for (int c = 0; c < attn_sb.eff_dim(); c++)
            if (!key_written[r][c])
               send_item(ACT_LOAD, 8'(r), 6'(c), pick_value(), pick_value());
   endtask

   // mostly whole query rows with random content, some loads and stray elements
   task automatic random_items(int count);
      int          done;
      int unsigned dim;
      int unsigned col;
      logic [7:0]  tag;
      bit          ok;
      done = 0;
      dim  = attn_sb.eff_dim();
      while (done < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               send_item(ACT_LOAD, 8'($urandom), 6'($urandom), pick_value(), pick_value());
               done++;
            end
            3: begin
               col = $urandom_range(0, 63);
               ok  = 1'b1;
               if (col == dim - 1)
                  for (int c = 0; c < dim; c++) if (!q_written[c]) ok = 1'b0;
               if (ok) begin
                  send_item(ACT_QUERY, 8'($urandom), 6'(col), pick_value(), 16'($urandom));
                  done++;
               end
            end
            default: begin
               tag = 8'($urandom);
               for (int c = 0; c < dim; c++)
                  send_item(ACT_QUERY, tag, 6'(c), pick_value(), 16'($urandom));
               done += dim;
            end
         endcase
      end
   endtask

   // receiver: own stall pattern, plus one long hold-off while items are offered
   initial begin : receiver
      attn_out_type got;
      int           mode_left;
      bit           choppy;
      bit           held;
      string        msg;
      rsp_if.ready = 1'b0;
      mode_left    = 0;
      choppy       = 1'b0;
      held         = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got.query_row = rsp_if.query_row;
            got.out_col   = rsp_if.out_col;
            got.out_value = rsp_if.out_value;
            got.last      = rsp_if.last;
            outputs_seen++;
            if (attn_sb.expected.size() == 0) begin
               report($sformatf("unexpected output row %0d col %0d",
                  got.query_row, got.out_col));
            end else begin
               msg = attn_sb.check(got);
               if (msg != "") report(msg);
            end
         end
         if (!held && outputs_seen >= 10 && req_if.valid) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (3000) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(20, 300);
               choppy    = $urandom_range(0, 1);
            end
            mode_left--;
            rsp_if.ready <= choppy ? ($urandom_range(0, 2) == 0) : 1'b1;
         end
      end
   end

   initial begin : stimulus
      attn_sb      = new();
      fail_count   = 0;
      items_sent   = 0;
      outputs_seen = 0;
      queries_done = 0;
      burst_left   = 0;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      req_if.valid    <= 1'b0;
      req_if.action   <= ACT_LOAD;
      req_if.row      <= '0;
      req_if.col      <= '0;
      req_if.qk_value <= '0;
      req_if.v_value  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one key, largest scale, extreme values and tags
      write_regs(1, 1, 65535);
      send_item(ACT_LOAD, 8'd0, 6'd0, 16'h7fff, 16'h7fff);
      send_item(ACT_QUERY, 8'd255, 6'd0, 16'h7fff, 16'h0000);
      send_item(ACT_LOAD, 8'd0, 6'd0, 16'h8000, 16'h8000);
      send_item(ACT_QUERY, 8'd0, 6'd0, 16'h8000, 16'hffff);
      // columns past head_dim are stored but answer nothing
      send_item(ACT_QUERY, 8'd7, 6'd63, 16'h8000, 16'h7fff);
      send_item(ACT_QUERY, 8'd8, 6'd5, 16'h1234, 16'h0000);
      send_item(ACT_LOAD, 8'd255, 6'd63, 16'h7fff, 16'h8000);
      send_item(ACT_QUERY, 8'hAA, 6'd0, 16'h0001, 16'h0000);
      drain();

      // zero registers clamp to one row, one column; zero scale flattens scores
      write_regs(0, 0, 0);
      send_item(ACT_LOAD, 8'd0, 6'd0, 16'h4000, 16'h8000);
      send_item(ACT_QUERY, 8'h55, 6'd0, 16'h7fff, 16'h0000);
      random_items(8);
      drain();

      // crosses a key-block boundary; pause mid-phase until all outputs are out
      write_regs(33, 1, 20000);
      fill_keys();
      random_items(8);
      drain();
      random_items(8);
      drain();

      write_regs(5, 3, 8192);
      fill_keys();
      random_items(20);
      drain();

      write_regs(6, 8, 4096);
      fill_keys();
      random_items(20);
      drain();

      // settle after the last output before judging
      repeat (100) @(posedge clock);
      $display("tb: %0d items sent, %0d queries completed, %0d outputs checked",
         items_sent, queries_done, outputs_seen);
      $display("tb: five register settings, zero-size clamps, block crossing, long stall");
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
